// ----- rtl/ncd_pkg.sv -----
// Shared types, constants and helpers for the nearest car call dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package ncd_pkg;

   localparam int FLOOR_W      = 6;
   localparam int CAR_PORT_W   = 4;
   localparam int SLOT_PORT_W  = 6;
   localparam int COUNT_PORT_W = 7;
   localparam int CFG_W        = 5;
   localparam int REQ_DATA_W   = 16;
   localparam int REQ_USER_W   = 2;
   localparam int RSP_DATA_W   = 48;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_RELEASE  = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef struct packed {
      logic [FLOOR_W-1:0] origin;
      logic [FLOOR_W-1:0] dest;
   } entry_type;

   typedef struct packed {
      logic load;
      logic take;
   } cell_ctrl_type;

   function automatic logic [FLOOR_W-1:0] floor_dist(input logic [FLOOR_W-1:0] a,
                                                     input logic [FLOOR_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ncd_call_cell.sv -----
// One cell of the pending call chain: holds a call and loads it or takes its neighbour's.
`timescale 1ns / 1ps
`default_nettype none

module ncd_call_cell
   import ncd_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     load_data,
   input  entry_type     next_data,
   output entry_type     q
);

   entry_type q_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         q_ff <= load_data;
      end else if (ctrl.take) begin
         q_ff <= next_data;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

// ----- rtl/ncd_car_search.sv -----
// Registered minimum tree that finds the nearest free car for one call per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ncd_car_search
   import ncd_pkg::*;
#(
   parameter int CARS       = 16,
   parameter int CALL_SLOTS = 64
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          feed_valid,
   input  logic [$clog2(CALL_SLOTS)-1:0] feed_slot,
   input  entry_type                     feed_entry,
   input  logic [FLOOR_W-1:0]            car_floor [CARS],
   input  logic [CARS-1:0]               consider,
   output logic                          res_valid,
   output logic [FLOOR_W-1:0]            res_dist,
   output logic [$clog2(CARS)-1:0]       res_car,
   output logic [$clog2(CALL_SLOTS)-1:0] res_slot,
   output entry_type                     res_entry
);

   localparam int CW  = $clog2(CARS);
   localparam int SLW = $clog2(CALL_SLOTS);
   localparam int L   = $clog2(CARS);
   localparam int P   = 1 << L;

   typedef struct packed {
      logic               valid;
      logic [FLOOR_W-1:0] span;
      logic [CW-1:0]      car;
   } node_type;

   typedef struct packed {
      logic           valid;
      logic [SLW-1:0] slot;
      entry_type      entry;
   } tag_type;

   // The lower index wins a tie, which keeps the first car found.
   function automatic node_type pick(input node_type a, input node_type b);
      return (a.valid && (!b.valid || a.span <= b.span)) ? a : b;
   endfunction

   node_type leaf       [P];
   node_type lvl_ff     [L+1][P];
   tag_type  tag_ff     [L+1];

   genvar j, lv, k;

   generate
      for (j = 0; j < P; j++) begin : g_leaf
         if (j < CARS) begin : g_car
            assign leaf[j] = '{valid: feed_valid && consider[j],
                               span:  floor_dist(car_floor[j], feed_entry.origin),
                               car:   CW'(j)};
         end else begin : g_pad
            assign leaf[j] = '0;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               lvl_ff[0][j] <= '0;
            end else begin
               lvl_ff[0][j] <= leaf[j];
            end
         end
      end

      for (lv = 1; lv <= L; lv++) begin : g_level
         for (k = 0; k < (P >> lv); k++) begin : g_node
            always_ff @(posedge clock) begin
               if (reset) begin
                  lvl_ff[lv][k] <= '0;
               end else begin
                  lvl_ff[lv][k] <= pick(lvl_ff[lv-1][2*k], lvl_ff[lv-1][2*k+1]);
               end
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               tag_ff[lv] <= '0;
            end else begin
               tag_ff[lv] <= tag_ff[lv-1];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else begin
         tag_ff[0] <= '{valid: feed_valid, slot: feed_slot, entry: feed_entry};
      end
   end

   assign res_valid = lvl_ff[L][0].valid && tag_ff[L].valid;
   assign res_dist  = lvl_ff[L][0].span;
   assign res_car   = lvl_ff[L][0].car;
   assign res_slot  = tag_ff[L].slot;
   assign res_entry = tag_ff[L].entry;

endmodule

`default_nettype wire

// ----- rtl/nearest_car_call_dispatcher_unit.sv -----
// Top level of the nearest car call dispatcher: call chain, car table and sequencer.
// Add call, release and unknown requests go from idle to the finish state, where the result
// is registered once the response side is free. Dispatch rotates the call chain once through
// all CALL_SLOTS cells while the car search tree compares every car against one call a cycle.
// One request is in progress at a time; the next is taken in the cycle after the result is
// registered, even while that result still waits on the response side.
// Reset is synchronous: no calls pending, all cars free at floor zero, cars in use set to 16.
`timescale 1ns / 1ps
`default_nettype none

module nearest_car_call_dispatcher_unit
   import ncd_pkg::*;
#(
   parameter int CALL_SLOTS = 64,
   parameter int CARS       = 16,
   parameter int FLOORS     = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // origin_floor[5:0], dest_floor[11:6], car_index[15:12]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accepted[0], found[1], chosen_car[5:2], call_slot[11:6], served_origin[17:12],
   // served_dest[23:18], pickup_distance[29:24], trip_floors[35:30],
   // pending_count[42:36], zero[47:43]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data
);

   localparam int CW       = $clog2(CARS);
   localparam int SLW      = $clog2(CALL_SLOTS);
   localparam int SW       = $clog2(CALL_SLOTS + 1);
   localparam int D        = $clog2(CARS) + 1;
   localparam int CTR_W    = $clog2(CALL_SLOTS + D + 1);
   localparam int LAST_CTR = CALL_SLOTS + D - 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff;
   logic [FLOOR_W-1:0]  org_ff, dst_ff;
   logic [CAR_PORT_W-1:0] car_ff;
   logic [SW-1:0]       count_ff, count_in;
   logic [CTR_W-1:0]    ctr_ff, ctr_in;
   logic                best_have_ff, best_have_in;
   logic [FLOOR_W-1:0]  best_dist_ff;
   logic [CW-1:0]       best_car_ff;
   logic [SLW-1:0]      best_slot_ff;
   entry_type           best_entry_ff;
   logic [FLOOR_W-1:0]  car_floor_ff [CARS];
   logic [CARS-1:0]     car_busy_ff, car_busy_in;
   logic [CFG_W-1:0]    cfg_ff;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                accept, rotate, feed_valid, out_free, commit;
   logic                is_add, is_dispatch, is_release, add_ok, found, merge;
   logic [FLOOR_W-1:0]  org_clamped, dst_clamped;
   logic [CARS-1:0]     consider;
   logic [CW+3:0]       car_ext;
   logic [SLW+5:0]      slot_ext;
   logic [SW+6:0]       count_ext;
   logic [FLOOR_W-1:0]  trip;

   logic                res_valid;
   logic [FLOOR_W-1:0]  res_dist;
   logic [CW-1:0]       res_car;
   logic [SLW-1:0]      res_slot;
   entry_type           res_entry;

   entry_type           cell_q    [CALL_SLOTS];
   cell_ctrl_type       cell_ctrl [CALL_SLOTS];
   entry_type           new_entry;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign accept      = req_tvalid && req_tready;
   assign rotate      = (state_ff == ST_SCAN) && (ctr_ff < CTR_W'(CALL_SLOTS));
   assign feed_valid  = rotate && (32'(ctr_ff) < 32'(count_ff));
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign commit      = (state_ff == ST_FINISH) && out_free;
   assign is_add      = (op_ff == OP_ADD);
   assign is_dispatch = (op_ff == OP_DISPATCH);
   assign is_release  = (op_ff == OP_RELEASE);
   assign add_ok      = 32'(count_ff) < CALL_SLOTS;
   assign found       = is_dispatch && best_have_ff;
   // Across calls an equal distance keeps the earlier call.
   assign merge       = (state_ff == ST_SCAN) && res_valid &&
                        (!best_have_ff || res_dist < best_dist_ff);

   // Floors beyond the top of the building are stored as the top floor.
   assign org_clamped = (32'(org_ff) > FLOORS - 1) ? FLOOR_W'(FLOORS - 1) : org_ff;
   assign dst_clamped = (32'(dst_ff) > FLOORS - 1) ? FLOOR_W'(FLOORS - 1) : dst_ff;
   assign new_entry   = '{origin: org_clamped, dest: dst_clamped};

   always_comb begin
      for (int j = 0; j < CARS; j++) begin
         consider[j] = (32'(cfg_ff) > j) && !car_busy_ff[j];
      end
   end

   genvar i;
   generate
      for (i = 0; i < CALL_SLOTS; i++) begin : g_cell
         assign cell_ctrl[i] = '{
            load: commit && is_add && add_ok && (count_ff == SW'(i)),
            take: rotate || (commit && found && (SLW'(i) >= best_slot_ff))
         };

         ncd_call_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[i]),
            .load_data (new_entry),
            .next_data (cell_q[(i + 1) % CALL_SLOTS]),
            .q         (cell_q[i])
         );
      end
   endgenerate

   ncd_car_search #(
      .CARS       (CARS),
      .CALL_SLOTS (CALL_SLOTS)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .feed_valid (feed_valid),
      .feed_slot  (ctr_ff[SLW-1:0]),
      .feed_entry (cell_q[0]),
      .car_floor  (car_floor_ff),
      .consider   (consider),
      .res_valid  (res_valid),
      .res_dist   (res_dist),
      .res_car    (res_car),
      .res_slot   (res_slot),
      .res_entry  (res_entry)
   );

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      best_have_in = best_have_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctr_in       = '0;
               best_have_in = 1'b0;
               state_in     = (op_type'(req_tuser) == OP_DISPATCH) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            ctr_in = ctr_ff + CTR_W'(1);
            if (merge) begin
               best_have_in = 1'b1;
            end
            if (ctr_ff == CTR_W'(LAST_CTR)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      car_busy_in = car_busy_ff;
      if (commit) begin
         if (is_add && add_ok) begin
            count_in = count_ff + SW'(1);
         end
         if (found) begin
            count_in = count_ff - SW'(1);
         end
         for (int j = 0; j < CARS; j++) begin
            if (found && best_car_ff == CW'(j)) begin
               car_busy_in[j] = 1'b1;
            end
            if (is_release && 32'(car_ff) == j) begin
               car_busy_in[j] = 1'b0;
            end
         end
      end
   end

   assign car_ext   = {4'b0, best_car_ff};
   assign slot_ext  = {6'b0, best_slot_ff};
   assign count_ext = {7'b0, count_in};
   assign trip      = floor_dist(best_entry_ff.dest, best_entry_ff.origin);

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[0]     = is_add && add_ok;
      rsp_data_in[42:36] = count_ext[COUNT_PORT_W-1:0];
      if (found) begin
         rsp_data_in[1]     = 1'b1;
         rsp_data_in[5:2]   = car_ext[CAR_PORT_W-1:0];
         rsp_data_in[11:6]  = slot_ext[SLOT_PORT_W-1:0];
         rsp_data_in[17:12] = best_entry_ff.origin;
         rsp_data_in[23:18] = best_entry_ff.dest;
         rsp_data_in[29:24] = best_dist_ff;
         rsp_data_in[35:30] = trip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctr_ff       <= '0;
         best_have_ff <= 1'b0;
         count_ff     <= '0;
         car_busy_ff  <= '0;
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         best_have_ff <= best_have_in;
         count_ff     <= count_in;
         car_busy_ff  <= car_busy_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_data;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < CARS; j++) begin
            car_floor_ff[j] <= '0;
         end
      end else if (commit && found) begin
         for (int j = 0; j < CARS; j++) begin
            if (best_car_ff == CW'(j)) begin
               car_floor_ff[j] <= best_entry_ff.dest;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_tuser);
         org_ff <= req_tdata[5:0];
         dst_ff <= req_tdata[11:6];
         car_ff <= req_tdata[15:12];
      end
      if (merge) begin
         best_dist_ff  <= res_dist;
         best_car_ff   <= res_car;
         best_slot_ff  <= res_slot;
         best_entry_ff <= res_entry;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CALL_SLOTS)
      else $error("pending call count beyond list depth");

   a_best_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && best_have_ff) |-> (32'(best_slot_ff) < 32'(count_ff)))
      else $error("chosen call lies outside the pending list");

   a_dispatch_pops: assert property (@(posedge clock) disable iff (reset)
      (commit && found) |=> (count_ff == $past(count_ff) - SW'(1)))
      else $error("dispatch did not remove exactly one call");

   a_found_car_free: assert property (@(posedge clock) disable iff (reset)
      (merge && state_ff == ST_SCAN) |-> consider[res_car])
      else $error("search picked a busy or unused car");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_nearest_car_call_dispatcher_unit.sv -----
// Testbench for the nearest car call dispatcher: queued requests, predictor and checker.
`timescale 1ns / 1ps

module tb_nearest_car_call_dispatcher_unit;
   import ncd_pkg::*;

   localparam int CALL_SLOTS  = 64;
   localparam int CARS        = 16;
   localparam int QUIET_LIMIT = 5000;

   typedef struct packed {
      op_type                 op;
      logic [FLOOR_W-1:0]     origin;
      logic [FLOOR_W-1:0]     dest;
      logic [CAR_PORT_W-1:0]  car;
   } call_request_type;

   typedef struct packed {
      logic                    accepted;
      logic                    found;
      logic [CAR_PORT_W-1:0]   chosen_car;
      logic [SLOT_PORT_W-1:0]  call_slot;
      logic [FLOOR_W-1:0]      served_origin;
      logic [FLOOR_W-1:0]      served_dest;
      logic [FLOOR_W-1:0]      pickup_distance;
      logic [FLOOR_W-1:0]      trip_floors;
      logic [COUNT_PORT_W-1:0] pending_count;
   } dispatch_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data;

   // Predicted state of the block.
   entry_type             call_list[$];
   logic [FLOOR_W-1:0]    car_floor[CARS];
   logic                  car_busy[CARS];
   logic [CFG_W-1:0]      cars_in_use;

   call_request_type      request_q[$];
   dispatch_outcome_type  outcome_q[$];
   int                    issued_count = 0;
   int                    taken_count = 0;
   int                    csr_writes = 0;
   int                    quiet_cycles = 0;
   int                    fail_count = 0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   bit                    req_fired = 1'b0;

   nearest_car_call_dispatcher_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int floor_gap(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Applies one request to the predicted state and returns the result it should give.
   function automatic dispatch_outcome_type predict_outcome(input op_type op,
                                                         input logic [FLOOR_W-1:0] origin,
                                                         input logic [FLOOR_W-1:0] dest,
                                                         input logic [CAR_PORT_W-1:0] car);
      dispatch_outcome_type res;
      entry_type         call;
      int                ncars;
      int                best_slot;
      int                best_car;
      int                best_dist;
      int                gap;
      bit                have;
      res = '0;
      ncars = (cars_in_use > CARS) ? CARS : cars_in_use;
      have = 1'b0;
      best_slot = 0;
      best_car = 0;
      best_dist = 0;
      case (op)
         OP_ADD: begin
            if (call_list.size() < CALL_SLOTS) begin
               call.origin = origin;
               call.dest = dest;
               call_list.push_back(call);
               res.accepted = 1'b1;
            end
         end
         OP_DISPATCH: begin
            for (int i = 0; i < call_list.size(); i++) begin
               for (int j = 0; j < ncars; j++) begin
                  if (!car_busy[j]) begin
                     gap = floor_gap(car_floor[j], call_list[i].origin);
                     // A later pairing only wins when it is strictly closer.
                     if (!have || gap < best_dist) begin
                        have = 1'b1;
                        best_dist = gap;
                        best_slot = i;
                        best_car = j;
                     end
                  end
               end
            end
            if (have) begin
               call = call_list[best_slot];
               call_list.delete(best_slot);
               car_busy[best_car] = 1'b1;
               car_floor[best_car] = call.dest;
               res.found = 1'b1;
               res.chosen_car = CAR_PORT_W'(best_car);
               res.call_slot = SLOT_PORT_W'(best_slot);
               res.served_origin = call.origin;
               res.served_dest = call.dest;
               res.pickup_distance = FLOOR_W'(best_dist);
               res.trip_floors = FLOOR_W'(floor_gap(call.dest, call.origin));
            end
         end
         OP_RELEASE: begin
            if (car < CARS)
               car_busy[car] = 1'b0;
         end
         default: ;
      endcase
      res.pending_count = COUNT_PORT_W'(call_list.size());
      return res;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Acceptance of requests, register writes and results, all sampled at the rising edge.
   always @(posedge clock) begin : bus_watch
      dispatch_outcome_type want;
      dispatch_outcome_type got;
      bit                moved;
      moved = 1'b0;
      req_fired = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            cars_in_use = csr_data;
            csr_writes++;
            moved = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(predict_outcome(op_type'(req_tuser), req_tdata[5:0],
                                                req_tdata[11:6], req_tdata[15:12]));
            taken_count++;
            req_fired = 1'b1;
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got.accepted = rsp_tdata[0];
            got.found = rsp_tdata[1];
            got.chosen_car = rsp_tdata[5:2];
            got.call_slot = rsp_tdata[11:6];
            got.served_origin = rsp_tdata[17:12];
            got.served_dest = rsp_tdata[23:18];
            got.pickup_distance = rsp_tdata[29:24];
            got.trip_floors = rsp_tdata[35:30];
            got.pending_count = rsp_tdata[42:36];
            if (outcome_q.size() == 0) begin
               $display("%0t: result with none expected, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               check_field("accepted", want.accepted, got.accepted);
               check_field("found", want.found, got.found);
               check_field("chosen_car", want.chosen_car, got.chosen_car);
               check_field("call_slot", want.call_slot, got.call_slot);
               check_field("served_origin", want.served_origin, got.served_origin);
               check_field("served_dest", want.served_dest, got.served_dest);
               check_field("pickup_distance", want.pickup_distance, got.pickup_distance);
               check_field("trip_floors", want.trip_floors, got.trip_floors);
               check_field("pending_count", want.pending_count, got.pending_count);
               check_field("padding", 0, rsp_tdata[47:43]);
            end
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   // Request driver and result-side back-pressure, both changed at the falling edge.
   always @(negedge clock) begin : request_drive
      call_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = request_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= item.op;
            req_tdata <= {item.car, item.dest, item.origin};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic queue_request(input op_type op, input int origin, input int dest,
                                input int car);
      call_request_type item;
      item.op = op;
      item.origin = FLOOR_W'(origin);
      item.dest = FLOOR_W'(dest);
      item.car = CAR_PORT_W'(car);
      request_q.push_back(item);
      issued_count++;
   endtask

   task automatic queue_random(input int count, input int add_pct, input int dispatch_pct,
                               input int release_pct);
      int     pick;
      op_type op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < add_pct)
            op = OP_ADD;
         else if (pick < add_pct + dispatch_pct)
            op = OP_DISPATCH;
         else if (pick < add_pct + dispatch_pct + release_pct)
            op = OP_RELEASE;
         else
            op = OP_NONE;
         queue_request(op, $urandom_range(63), $urandom_range(63), $urandom_range(15));
      end
   endtask

   task automatic wait_for_drain();
      while (taken_count != issued_count || outcome_q.size() != 0)
         @(negedge clock);
   endtask

   // The register is only written once every request has been answered.
   task automatic write_cars_in_use(input int value);
      int prior_writes;
      wait_for_drain();
      repeat (4) @(negedge clock);
      prior_writes = csr_writes;
      csr_data <= CFG_W'(value);
      csr_valid <= 1'b1;
      do
         @(negedge clock);
      while (csr_writes == prior_writes);
      csr_valid <= 1'b0;
   endtask

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("nearest_car_call_dispatcher_unit verification failed");
      $finish;
   end

   initial begin : stimulus
      int phase_cars[8];
      phase_cars = '{16, 31, 1, 0, 3, 17, 8, 16};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_ADD;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      cars_in_use = CFG_RESET;
      for (int c = 0; c < CARS; c++) begin
         car_floor[c] = '0;
         car_busy[c] = 1'b0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty list, floor extremes, ties, releases and the unknown op.
      queue_request(OP_DISPATCH, 0, 0, 0);
      queue_request(OP_ADD, 0, 63, 15);
      queue_request(OP_ADD, 63, 0, 0);
      queue_request(OP_ADD, 42, 21, 10);
      queue_request(OP_ADD, 21, 42, 5);
      queue_request(OP_DISPATCH, 63, 63, 15);
      queue_request(OP_DISPATCH, 0, 0, 0);
      queue_request(OP_RELEASE, 0, 0, 0);
      queue_request(OP_RELEASE, 0, 0, 0);
      queue_request(OP_RELEASE, 63, 63, 15);
      queue_request(OP_NONE, 63, 63, 15);
      queue_request(OP_NONE, 0, 0, 0);
      write_cars_in_use(0);
      queue_request(OP_DISPATCH, 21, 42, 10);
      write_cars_in_use(1);
      queue_request(OP_DISPATCH, 0, 0, 0);
      queue_request(OP_DISPATCH, 0, 0, 0);
      queue_request(OP_RELEASE, 0, 0, 0);
      queue_request(OP_DISPATCH, 0, 0, 0);
      queue_request(OP_RELEASE, 0, 0, 0);

      for (int p = 0; p < 8; p++) begin
         write_cars_in_use(phase_cars[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         if (p == 4) begin
            // Fill the call list past its capacity, then hold off until every result is in.
            queue_random(66, 100, 0, 0);
            wait_for_drain();
         end
         queue_random(42, 35, 35, 25);
      end

      wait_for_drain();
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("nearest_car_call_dispatcher_unit verification clean");
      else
         $display("nearest_car_call_dispatcher_unit verification failed");
      $finish;
   end

endmodule
